>>> rtl/core/multi_stack_engine_top_macros.svh
// Assertion macros for the multi-stack engine.
// Included by the RTL files that carry assertions; defines nothing else.
`ifndef MULTI_STACK_ENGINE_TOP_MACROS_SVH
`define MULTI_STACK_ENGINE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define MSK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("multi_stack_engine: assertion failed");
`define MSK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("multi_stack_engine: assertion failed");
`else
`define MSK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/msk_pkg.sv
// Shared types, codes and helpers of the multi-stack engine.
// Used by msk_store, multi_stack_engine_top and the testbench; depends on nothing.
`default_nettype none
package msk_pkg;

	localparam int DEF_STACK_COUNT   = 8;
	localparam int DEF_TOTAL_ENTRIES = 128;
	localparam int DEF_DATA_WIDTH    = 32;

	// fixed item field widths
	localparam int IDX_W    = 3;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 5;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_POP,
		ST_OUT
	} state_t;

	// memory strobes from the controller to the store
	typedef struct packed {
		logic fill_re;
		logic fill_we;
		logic entry_re;
		logic entry_we;
	} store_ctl_t;

	// stack index folded into the stack count by repeated subtraction
	function automatic logic [IDX_W-1:0] fold_index(logic [IDX_W-1:0] idx, int count);
		logic [IDX_W-1:0] v;
		v = idx;
		for (int i = 0; i < 4; i++) begin
			if (int'(v) >= count) begin
				v = v - IDX_W'(count);
			end
		end
		return v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/msk_store.sv
// Storage of the multi-stack engine: shared entry memory and per-stack fill memory.
// Both memories have a registered (synchronous) read; uses msk_pkg types.
`default_nettype none
module msk_store #(
	parameter int STACK_COUNT   = 8,
	parameter int TOTAL_ENTRIES = 128,
	parameter int STORE_WIDTH   = 32,
	parameter int FILL_WIDTH    = 5
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire msk_pkg::store_ctl_t        ctl,
	input  wire [$clog2(STACK_COUNT)-1:0]   fill_addr,
	input  wire [FILL_WIDTH-1:0]            fill_wdata,
	output logic [FILL_WIDTH-1:0]           fill_rdata,
	input  wire [$clog2(TOTAL_ENTRIES)-1:0] entry_addr,
	input  wire [STORE_WIDTH-1:0]           entry_wdata,
	output logic [STORE_WIDTH-1:0]          entry_rdata
);

	logic [STORE_WIDTH-1:0] entry_mem [TOTAL_ENTRIES];
	logic [FILL_WIDTH-1:0]  fill_mem  [STACK_COUNT];
	logic [STACK_COUNT-1:0] fill_valid_q;

	// entry memory: never cleared, a pop only reads words a push wrote
	always_ff @(posedge clk) begin
		if (ctl.entry_we) begin
			entry_mem[entry_addr] <= entry_wdata;
		end
		if (ctl.entry_re) begin
			entry_rdata <= entry_mem[entry_addr];
		end
	end

	// fill memory: an entry never written reads as empty
	always_ff @(posedge clk) begin
		if (ctl.fill_we) begin
			fill_mem[fill_addr] <= fill_wdata;
		end
		if (ctl.fill_re) begin
			fill_rdata <= fill_valid_q[fill_addr] ? fill_mem[fill_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_valid_q <= '0;
		end else if (ctl.fill_we) begin
			fill_valid_q[fill_addr] <= 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/multi_stack_engine_top.sv
// Top level of the multi-stack engine: stream ports, control sequencer, result register.
// Depends on msk_pkg, msk_store and multi_stack_engine_top_macros.svh.
//
// Several LIFO stacks share one entry memory, each owning a fixed segment of
// TOTAL_ENTRIES / STACK_COUNT words. An input item pushes a word onto a stack or
// pops its top; every item gives one result item with the popped word (zero
// unless a pop succeeded), a status (ok, full on a refused push, empty on a
// refused pop) and the stack's fill count afterwards. A stack index at or above
// STACK_COUNT wraps modulo the stack count. Items are handled one at a time:
// the fill count is read from its memory, then the entry memory is written
// (push) or read (pop). For a push or a refused operation the result is decided
// in ST_FILL and loaded into the result register from ST_OUT; a successful pop
// passes through ST_POP for the entry read in between. The next item is taken
// in ST_IDLE, after that load. The result register holds a finished item while
// the sink stalls, and a new item may be accepted meanwhile; that item then
// waits in ST_OUT before its load until the held item has left, so sink stalls
// delay its result. No clearing pass is needed after reset: fill counts start
// empty through per-stack valid bits.
`default_nettype none
`include "multi_stack_engine_top_macros.svh"
module multi_stack_engine_top #(
	parameter int STACK_COUNT   = msk_pkg::DEF_STACK_COUNT,
	parameter int TOTAL_ENTRIES = msk_pkg::DEF_TOTAL_ENTRIES,
	parameter int DATA_WIDTH    = msk_pkg::DEF_DATA_WIDTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,  // [31:0] push_value
	input  wire  [3:0]  s_tuser,  // [0] mode, [3:1] stack_index
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,  // [31:0] pop_value, [36:32] fill_count, rest zero
	output logic [1:0]  m_tuser   // [1:0] status
);
	import msk_pkg::*;

	localparam int SegDepth = TOTAL_ENTRIES / STACK_COUNT;
	localparam int FillW    = $clog2(SegDepth + 1);
	localparam int SidxW    = $clog2(STACK_COUNT);
	localparam int EntryAw  = $clog2(TOTAL_ENTRIES);
	localparam int StoreW   = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

	state_t state_q, state_d;

	// item being worked on
	logic              mode_q;
	logic [SidxW-1:0]  sidx_q;
	logic [StoreW-1:0] word_q;

	// result being built
	status_t           status_q;
	logic [FillW-1:0]  fill_res_q;
	logic [WORD_W-1:0] popped_q;

	// result register
	logic              out_valid_q;
	logic [WORD_W-1:0] out_pop_q;
	logic [FILL_W-1:0] out_fill_q;
	status_t           out_status_q;

	store_ctl_t        ctl;
	logic [SidxW-1:0]  in_sidx;
	logic [SidxW-1:0]  fill_addr;
	logic [FillW-1:0]  fill_rdata;
	logic [FillW-1:0]  fill_wdata;
	logic [EntryAw-1:0] entry_addr;
	logic [StoreW-1:0] entry_rdata;

	logic              in_accept;
	logic              out_free;
	logic              is_full;
	logic              is_empty;
	logic              op_ok;
	logic              res_load;
	logic              out_load;
	logic [FillW-1:0]  fill_next;
	status_t           status_next;

	assign in_sidx   = SidxW'(fold_index(s_tuser[3:1], STACK_COUNT));
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	// decision on the fill count read in the previous cycle
	assign is_full  = (int'(fill_rdata) >= SegDepth);
	assign is_empty = (fill_rdata == '0);
	assign op_ok    = (mode_q == MODE_PUSH) ? !is_full : !is_empty;

	always_comb begin
		fill_next   = fill_rdata;
		status_next = STAT_OK;
		if (mode_q == MODE_PUSH) begin
			if (is_full) begin
				status_next = STAT_FULL;
			end else begin
				fill_next = fill_rdata + FillW'(1);
			end
		end else begin
			if (is_empty) begin
				status_next = STAT_EMPTY;
			end else begin
				fill_next = fill_rdata - FillW'(1);
			end
		end
	end

	assign fill_addr  = (state_q == ST_IDLE) ? in_sidx : sidx_q;
	assign fill_wdata = fill_next;
	// push writes at the old top, pop reads at the new top
	assign entry_addr = EntryAw'(32'(sidx_q) * SegDepth + 32'(fill_rdata))
		- ((mode_q == MODE_POP) ? EntryAw'(1) : EntryAw'(0));

	// sequencer
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		ctl          = '0;
		res_load     = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				ctl.fill_re = 1'b1;
				if (s_tvalid) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				res_load     = 1'b1;
				ctl.fill_we  = op_ok;
				ctl.entry_we = op_ok && (mode_q == MODE_PUSH);
				ctl.entry_re = op_ok && (mode_q == MODE_POP);
				state_d      = (op_ok && (mode_q == MODE_POP)) ? ST_POP : ST_OUT;
			end
			ST_POP: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q <= s_tuser[0];
			sidx_q <= in_sidx;
			word_q <= s_tdata[StoreW-1:0];
		end
		if (res_load) begin
			status_q   <= status_next;
			fill_res_q <= fill_next;
			popped_q   <= '0;
		end
		if (state_q == ST_POP) begin
			popped_q <= WORD_W'(entry_rdata);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pop_q    <= popped_q;
			out_fill_q   <= FILL_W'(fill_res_q);
			out_status_q <= status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_fill_q, out_pop_q};
	assign m_tuser  = out_status_q;

	msk_store #(
		.STACK_COUNT   (STACK_COUNT),
		.TOTAL_ENTRIES (TOTAL_ENTRIES),
		.STORE_WIDTH   (StoreW),
		.FILL_WIDTH    (FillW)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.fill_addr   (fill_addr),
		.fill_wdata  (fill_wdata),
		.fill_rdata  (fill_rdata),
		.entry_addr  (entry_addr),
		.entry_wdata (word_q),
		.entry_rdata (entry_rdata)
	);

	// a refused operation never carries a word
	`MSK_ASSERT_IMP(a_refused_zero, clk, arst_n,
		m_tvalid && (m_tuser != STAT_OK), m_tdata[31:0] == '0)
	// the fill count never exceeds the segment
	`MSK_ASSERT_IMP(a_fill_bound, clk, arst_n,
		state_q == ST_OUT, int'(fill_res_q) <= SegDepth)
	// memory writes only happen for an operation that was allowed
	`MSK_ASSERT_IMP(a_write_ok, clk, arst_n,
		ctl.entry_we || ctl.fill_we, (state_q == ST_FILL) && op_ok)
	// an accepted item is decided in the following cycle
	`MSK_ASSERT_NXT(a_accept_fill, clk, arst_n, in_accept, state_q == ST_FILL)

endmodule
`default_nettype wire

>>> verif/multi_stack_engine_top_test.sv
// Self-checking testbench for multi_stack_engine_top: push/pop items on eight stacks.
// A scoreboard class predicts each result item; depends on msk_pkg and the DUT.
`timescale 1ns / 1ps
module multi_stack_engine_top_test;
	import msk_pkg::*;

	localparam int STACKS      = DEF_STACK_COUNT;
	localparam int SEG_WORDS   = DEF_TOTAL_ENTRIES / DEF_STACK_COUNT;
	localparam int STALL_LIMIT = 3000;  // cycles with no item moving on either side
	localparam int RANDOM_ITEMS = 1930;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] push_value
	logic [3:0]  s_tuser = '0;   // [0] mode, [3:1] stack_index
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [31:0] pop_value, [36:32] fill_count
	logic [1:0]  m_tuser;        // [1:0] status

	// no idling on either side while set
	bit quiet = 1'b0;

	typedef struct packed {
		logic [WORD_W-1:0] pop_value;
		status_t           status;
		logic [FILL_W-1:0] fill_count;
	} stack_result_t;

	// Tracks every stack's contents and queues the result each accepted item must produce.
	class stack_scoreboard;
		logic [WORD_W-1:0] words [STACKS][SEG_WORDS];
		int unsigned       depth [STACKS];
		stack_result_t     pending [$];
		int                errors;
		int                items_taken;

		function new();
			foreach (depth[i]) depth[i] = 0;
			errors = 0;
			items_taken = 0;
		endfunction

		function void note_item(logic mode, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] word);
			stack_result_t r;
			int s;
			s = int'(idx) % STACKS;
			r.pop_value = '0;
			r.status = STAT_OK;
			if (mode == MODE_PUSH) begin
				if (depth[s] >= SEG_WORDS) begin
					r.status = STAT_FULL;
				end else begin
					words[s][depth[s]] = word;
					depth[s]++;
				end
			end else begin
				if (depth[s] == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					depth[s]--;
					r.pop_value = words[s][depth[s]];
				end
			end
			r.fill_count = FILL_W'(depth[s]);
			pending.push_back(r);
			items_taken++;
		endfunction

		function void check_result(logic [WORD_W-1:0] pv, logic [STATUS_W-1:0] st,
				logic [FILL_W-1:0] fc);
			stack_result_t exp_r;
			if (pending.size() == 0) begin
				$error("result item with nothing expected: pop_value %h status %0d fill_count %0d",
					pv, st, fc);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (pv !== exp_r.pop_value) begin
				$error("pop_value: expected %h, got %h", exp_r.pop_value, pv);
				errors++;
			end
			if (st !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, st);
				errors++;
			end
			if (fc !== exp_r.fill_count) begin
				$error("fill_count: expected %0d, got %0d", exp_r.fill_count, fc);
				errors++;
			end
		endfunction
	endclass

	stack_scoreboard sb = new();

	multi_stack_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one item, hold it until taken, then maybe idle the input.
	task automatic send_item(logic mode, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] word);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= {idx, mode};
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_item(mode, idx, word);
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result side: check every taken item, stall at random, and once hold off
	// long enough that the engine backs up and refuses input.
	initial begin : result_sink
		int  stall_left;
		bit  backpressure_done;
		stall_left = 0;
		backpressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				sb.check_result(m_tdata[31:0], m_tuser, m_tdata[36:32]);
			if (!backpressure_done && sb.items_taken >= 700) begin
				stall_left = 400;
				backpressure_done = 1'b1;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall_left = idle_len();
			end
		end
	end

	// Ends the run if nothing moves for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
					(m_tvalid === 1'b1 && m_tready === 1'b1))
				idle = 0;
			else
				idle++;
		end
		$display("multi_stack_engine_top verification failed");
		$finish;
	end

	initial begin : stimulus
		int                push_pct;
		int                hot_stack;
		int                r;
		logic              mode;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] word;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: underflow on a fresh stack, fill one stack to the top, overflow it
		// and pop it once, then data extremes on the highest stack index and a push to stack 0.
		send_item(MODE_POP, 3'd5, 32'hDEAD_BEEF);
		for (int i = 0; i < SEG_WORDS; i++)
			send_item(MODE_PUSH, 3'd3, $urandom);
		send_item(MODE_PUSH, 3'd3, 32'h1234_5678);   // refused, stack full
		send_item(MODE_POP, 3'd3, 32'hFFFF_FFFF);
		send_item(MODE_PUSH, 3'd7, 32'hFFFF_FFFF);
		send_item(MODE_PUSH, 3'd7, 32'h0000_0000);
		send_item(MODE_POP, 3'd7, '0);
		send_item(MODE_POP, 3'd7, '0);
		send_item(MODE_PUSH, 3'd0, 32'hA5A5_5A5A);

		// Random: push bias shifts per phase so stacks swing between full and
		// empty; a hot stack gets most of the traffic within a phase.
		push_pct = 50;
		hot_stack = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0) begin
				case ($urandom_range(0, 4))
					0: push_pct = 85;
					1: push_pct = 15;
					2: push_pct = 50;
					3: push_pct = 70;
					default: push_pct = 30;
				endcase
				hot_stack = $urandom_range(0, STACKS - 1);
			end
			quiet = (n >= 1000 && n < 1200);
			mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
			idx = ($urandom_range(0, 99) < 60) ? IDX_W'(hot_stack)
				: IDX_W'($urandom_range(0, STACKS - 1));
			r = $urandom_range(0, 99);
			if (r < 8)
				word = '1;
			else if (r < 16)
				word = '0;
			else
				word = $urandom;
			send_item(mode, idx, word);
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("multi_stack_engine_top verification clean");
		else
			$display("multi_stack_engine_top verification failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/msk_pkg.sv
rtl/core/msk_store.sv
rtl/core/multi_stack_engine_top.sv
verif/multi_stack_engine_top_test.sv
